// ----- hdl/ipk_pkg.sv -----
// Shared types, quadrant codes and the quarter-wave sine table for the
// inverse Park transform. No dependencies.
`timescale 1ns / 1ps

package ipk_pkg;

  // quadrant codes, bits 9:8 of the offset angle index
  localparam logic [1:0] QUAD_180_270 = 2'b00;
  localparam logic [1:0] QUAD_270_360 = 2'b01;
  localparam logic [1:0] QUAD_0_90    = 2'b10;
  localparam logic [1:0] QUAD_90_180  = 2'b11;

  // table sine and cosine of one angle, Q15
  typedef struct packed {
    logic signed [15:0] sine;
    logic signed [15:0] cosine;
  } sincos_t;

  // first quadrant of a sine wave, peak 0x7FFE
  localparam logic [15:0] QUARTER_SINE [256] = '{
    16'h0000,16'h00C9,16'h0192,16'h025B,16'h0324,16'h03ED,16'h04B6,16'h057F,
    16'h0648,16'h0711,16'h07D9,16'h08A2,16'h096A,16'h0A33,16'h0AFB,16'h0BC4,
    16'h0C8C,16'h0D54,16'h0E1C,16'h0EE3,16'h0FAB,16'h1072,16'h113A,16'h1201,
    16'h12C8,16'h138F,16'h1455,16'h151C,16'h15E2,16'h16A8,16'h176E,16'h1833,
    16'h18F9,16'h19BE,16'h1A82,16'h1B47,16'h1C0B,16'h1CCF,16'h1D93,16'h1E57,
    16'h1F1A,16'h1FDD,16'h209F,16'h2161,16'h2223,16'h22E5,16'h23A6,16'h2467,
    16'h2528,16'h25E8,16'h26A8,16'h2767,16'h2826,16'h28E5,16'h29A3,16'h2A61,
    16'h2B1F,16'h2BDC,16'h2C99,16'h2D55,16'h2E11,16'h2ECC,16'h2F87,16'h3041,
    16'h30FB,16'h31B5,16'h326E,16'h3326,16'h33DF,16'h3496,16'h354D,16'h3604,
    16'h36BA,16'h376F,16'h3824,16'h38D9,16'h398C,16'h3A40,16'h3AF2,16'h3BA5,
    16'h3C56,16'h3D07,16'h3DB8,16'h3E68,16'h3F17,16'h3FC5,16'h4073,16'h4121,
    16'h41CE,16'h427A,16'h4325,16'h43D0,16'h447A,16'h4524,16'h45CD,16'h4675,
    16'h471C,16'h47C3,16'h4869,16'h490F,16'h49B4,16'h4A58,16'h4AFB,16'h4B9D,
    16'h4C3F,16'h4CE0,16'h4D81,16'h4E20,16'h4EBF,16'h4F5D,16'h4FFB,16'h5097,
    16'h5133,16'h51CE,16'h5268,16'h5302,16'h539B,16'h5432,16'h54C9,16'h5560,
    16'h55F5,16'h568A,16'h571D,16'h57B0,16'h5842,16'h58D3,16'h5964,16'h59F3,
    16'h5A82,16'h5B0F,16'h5B9C,16'h5C28,16'h5CB3,16'h5D3E,16'h5DC7,16'h5E4F,
    16'h5ED7,16'h5F5D,16'h5FE3,16'h6068,16'h60EB,16'h616E,16'h61F0,16'h6271,
    16'h62F1,16'h6370,16'h63EE,16'h646C,16'h64E8,16'h6563,16'h65DD,16'h6656,
    16'h66CF,16'h6746,16'h67BC,16'h6832,16'h68A6,16'h6919,16'h698B,16'h69FD,
    16'h6A6D,16'h6ADC,16'h6B4A,16'h6BB7,16'h6C23,16'h6C8E,16'h6CF8,16'h6D61,
    16'h6DC9,16'h6E30,16'h6E96,16'h6EFB,16'h6F5E,16'h6FC1,16'h7022,16'h7083,
    16'h70E2,16'h7140,16'h719D,16'h71F9,16'h7254,16'h72AE,16'h7307,16'h735E,
    16'h73B5,16'h740A,16'h745F,16'h74B2,16'h7504,16'h7555,16'h75A5,16'h75F3,
    16'h7641,16'h768D,16'h76D8,16'h7722,16'h776B,16'h77B3,16'h77FA,16'h783F,
    16'h7884,16'h78C7,16'h7909,16'h794A,16'h7989,16'h79C8,16'h7A05,16'h7A41,
    16'h7A7C,16'h7AB6,16'h7AEE,16'h7B26,16'h7B5C,16'h7B91,16'h7BC5,16'h7BF8,
    16'h7C29,16'h7C59,16'h7C88,16'h7CB6,16'h7CE3,16'h7D0E,16'h7D39,16'h7D62,
    16'h7D89,16'h7DB0,16'h7DD5,16'h7DFA,16'h7E1D,16'h7E3E,16'h7E5F,16'h7E7E,
    16'h7E9C,16'h7EB9,16'h7ED5,16'h7EEF,16'h7F09,16'h7F21,16'h7F37,16'h7F4D,
    16'h7F61,16'h7F74,16'h7F86,16'h7F97,16'h7FA6,16'h7FB4,16'h7FC1,16'h7FCD,
    16'h7FD8,16'h7FE1,16'h7FE9,16'h7FF0,16'h7FF5,16'h7FF9,16'h7FFD,16'h7FFE
  };

endpackage

// ----- hdl/inverse_park_with_sine_table_top.sv -----
// Top level of the inverse Park transform: stream ports, input register,
// single-pass arithmetic and result register. Depends on ipk_pkg and ipk_sincos.
`timescale 1ns / 1ps

// Inverse Park transform, Q15. Each input item carries an angle and a
// (q, d) voltage pair. Each input item produces exactly one result item
// holding alpha, beta, the table sine and cosine, and an overflow flag. The
// flag is set when alpha or beta left the signed 16-bit range, and the field
// then holds the wrapped value. The block has two register stages and
// accepts one item per clock unless the receiver stalls. An accepted item
// sits in the input register. One combinational pass then runs from the
// input register into the result register: table lookup, four 16x16
// products, and the sums with truncating Q15 scaling. A stalled receiver
// holds the result register. The input register then takes one more
// item and the input stalls, so the block holds at most two items.
module inverse_park_with_sine_table_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // angle, voltage_q, voltage_d
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [63:0] m_axis_tdata_o,   // voltage_alpha, voltage_beta, sine_value, cosine_value
  output logic        m_axis_tuser_o    // overflow
);

  // stage valid bits and per-stage advance enables
  logic v0_q, v1_q;
  logic rdy0, rdy1;

  assign rdy1 = !v1_q || m_axis_tready_i;
  assign rdy0 = !v0_q || rdy1;
  assign s_axis_tready_o = rdy0;

  // stage payloads
  logic signed [15:0] angle_q, q0_q, d0_q;
  ipk_pkg::sincos_t   sc_d, sc_q;
  logic signed [15:0] alpha_q, beta_q;
  logic               ovf_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= s_axis_tvalid_i;
      if (rdy1) v1_q <= v0_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid_i) begin
      angle_q <= $signed(s_axis_tdata_i[15:0]);
      q0_q    <= $signed(s_axis_tdata_i[31:16]);
      d0_q    <= $signed(s_axis_tdata_i[47:32]);
    end
  end

  // table lookup
  ipk_sincos u_sincos (
    .angle_i  (angle_q),
    .sincos_o (sc_d)
  );

  // products, sums, truncating divide by 2^15 and range check
  // magnitudes stay below 2^31, so 32 bits hold every sum
  logic signed [31:0] qc, ds, dc, qs;
  logic signed [31:0] asum, bsum, abias, bbias;
  logic signed [16:0] aquo, bquo;
  logic               ovf_d;

  always_comb begin
    qc    = q0_q * sc_d.cosine;
    ds    = d0_q * sc_d.sine;
    dc    = d0_q * sc_d.cosine;
    qs    = q0_q * sc_d.sine;
    asum  = qc + ds;
    bsum  = dc - qs;
    abias = asum + (asum[31] ? 32'sd32767 : 32'sd0);
    bbias = bsum + (bsum[31] ? 32'sd32767 : 32'sd0);
    aquo  = abias[31:15];
    bquo  = bbias[31:15];
    ovf_d = (aquo[16] != aquo[15]) || (bquo[16] != bquo[15]);
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (rdy1 && v0_q) begin
      alpha_q <= aquo[15:0];
      beta_q  <= bquo[15:0];
      sc_q    <= sc_d;
      ovf_q   <= ovf_d;
    end
  end

  assign m_axis_tvalid_o = v1_q;
  assign m_axis_tdata_o  = {sc_q.cosine, sc_q.sine, beta_q, alpha_q};
  assign m_axis_tuser_o  = ovf_q;

  // an empty result register frees the whole block
  a_ready_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v1_q |-> s_axis_tready_o)
    else $error("input not ready while result register is empty");

  // table values never reach full scale negative
  a_sincos_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> (sc_q.sine != -16'sd32768) && (sc_q.cosine != -16'sd32768))
    else $error("sine or cosine out of table range");

  // a stalled result item holds its value
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && !m_axis_tready_i) |=> v1_q && $stable(m_axis_tdata_o) && $stable(ovf_q))
    else $error("result item changed under stall");

  // an input item moved forward lands in the result register
  a_in_to_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v0_q && rdy1) |=> v1_q)
    else $error("result register missed an item");

endmodule

// ----- hdl/ipk_sincos.sv -----
// Angle to table sine and cosine: quadrant decode, mirroring and negation
// of the quarter-wave table. Depends on ipk_pkg.
`timescale 1ns / 1ps

module ipk_sincos (
  input  logic signed [15:0] angle_i,
  output ipk_pkg::sincos_t   sincos_o
);

  logic [1:0]  quad;
  logic [7:0]  lo;
  logic [15:0] direct;
  logic [15:0] mirror;

  // offset by half a turn and drop six bits: index = {~a[15], a[14:6]}
  assign quad   = {~angle_i[15], angle_i[14]};
  assign lo     = angle_i[13:6];
  assign direct = ipk_pkg::QUARTER_SINE[lo];
  assign mirror = ipk_pkg::QUARTER_SINE[~lo];

  // quadrant selects mirrored entry and signs
  always_comb begin
    unique case (quad)
      ipk_pkg::QUAD_0_90: begin
        sincos_o.sine   = $signed(direct);
        sincos_o.cosine = $signed(mirror);
      end
      ipk_pkg::QUAD_90_180: begin
        sincos_o.sine   = $signed(mirror);
        sincos_o.cosine = $signed(16'(-direct));
      end
      ipk_pkg::QUAD_180_270: begin
        sincos_o.sine   = $signed(16'(-direct));
        sincos_o.cosine = $signed(16'(-mirror));
      end
      default: begin
        sincos_o.sine   = $signed(16'(-mirror));
        sincos_o.cosine = $signed(direct);
      end
    endcase
  end

endmodule
